FILE: rtl/planar_line_to_mirrored_bgr_defines.svh
// Assertion helpers. Clock aclk and active-low reset aresetn are taken
// from the scope that uses them.
`ifndef PLANAR_LINE_TO_MIRRORED_BGR_DEFINES_SVH
`define PLANAR_LINE_TO_MIRRORED_BGR_DEFINES_SVH

`ifndef SYNTHESIS

// cond must hold at every clock edge outside reset
`define PLMB_ASSERT(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("assertion failed");

// ante implies cons in the same cycle
`define PLMB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// ante implies cons in the following cycle
`define PLMB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PLMB_ASSERT(label, cond)
`define PLMB_ASSERT_IMP(label, ante, cons)
`define PLMB_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: rtl/pl2bgr_pkg.sv
package pl2bgr_pkg;

    localparam int BYTE_W   = 8;
    localparam int LW_W     = 14;   // line_width register
    localparam int SKIP_W   = 8;    // skip_lines register
    localparam int DEST_W   = 13;   // dest_index field
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = LW_W;
    localparam int PLANES   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH = 1'b0,
        CFG_SKIP_LINES = 1'b1
    } cfg_index_t;

    typedef enum logic {
        CMD_DATA  = 1'b0,
        CMD_START = 1'b1
    } cmd_t;

endpackage

FILE: rtl/planar_line_to_mirrored_bgr.sv
// Path: a red byte is registered in the read slot, beside the memory read
//   register, then in the output register, which drives the m_ side.
// Throughput: one byte per cycle while m_ready is high; each byte costs one
//   write or one read of the plane memories, which sets the rate.
// Reset (aresetn low, synchronous): byte position, skip count, pipeline valids
//   and config clear (line_width 1, skip_lines 0); plane memories are not cleared.
`include "planar_line_to_mirrored_bgr_defines.svh"

module planar_line_to_mirrored_bgr
    import pl2bgr_pkg::*;
#(
    parameter int MAX_WIDTH = 8192
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // byte stream in
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [BYTE_W-1:0]     s_raw_byte,

    // packed pixel out
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DEST_W-1:0]     m_dest_index,
    output logic [BYTE_W-1:0]     m_blue,
    output logic [BYTE_W-1:0]     m_green,
    output logic [BYTE_W-1:0]     m_red,
    output logic                  m_line_end
);

    // AW: plane address, WW: holds MAX_WIDTH, PW: holds 3*MAX_WIDTH
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int PW  = $clog2(PLANES * MAX_WIDTH + 1);
    localparam int CW  = (WW > LW_W) ? WW : LW_W;
    localparam int DXW = (WW > DEST_W) ? WW : DEST_W;

    // ------------------------------------------------------------------
    // Configuration. The effective width (clamped to 1..MAX_WIDTH) and its
    // multiples are worked out at write time, so an item may follow the
    // write directly.
    // ------------------------------------------------------------------
    logic [WW-1:0]     w_reg;
    logic [PW-1:0]     w2_reg;
    logic [PW-1:0]     w3_reg;
    logic [SKIP_W-1:0] skip_lines_reg;

    logic [CW-1:0]     lw_ext;
    logic [WW-1:0]     w_next;
    logic [PW-1:0]     w2_next;
    logic [PW-1:0]     w3_next;

    always_comb begin
        lw_ext = CW'(cfg_wdata);
        if (lw_ext == '0) begin
            w_next = WW'(1);
        end else if (lw_ext > CW'(MAX_WIDTH)) begin
            w_next = WW'(MAX_WIDTH);
        end else begin
            w_next = lw_ext[WW-1:0];
        end
        w2_next = PW'(w_next) << 1;
        w3_next = w2_next + PW'(w_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg          <= WW'(1);
            w2_reg         <= PW'(2);
            w3_reg         <= PW'(PLANES);
            skip_lines_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LINE_WIDTH: begin
                    w_reg  <= w_next;
                    w2_reg <= w2_next;
                    w3_reg <= w3_next;
                end
                CFG_SKIP_LINES: skip_lines_reg <= cfg_wdata[SKIP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Byte position decode. A position left beyond the line by a width
    // change restarts the line.
    // ------------------------------------------------------------------
    logic [PW-1:0]     pos_reg;
    logic [SKIP_W-1:0] lines_to_skip_reg;

    logic [PW-1:0] pos_eff;
    logic [PW-1:0] pos_inc;
    logic [PW-1:0] green_off;
    logic [PW-1:0] red_off;
    logic          in_blue;
    logic          in_green;
    logic          in_red;
    logic          wrap;

    always_comb begin
        pos_eff   = (pos_reg >= w3_reg) ? '0 : pos_reg;
        in_blue   = pos_eff < PW'(w_reg);
        in_green  = !in_blue && (pos_eff < w2_reg);
        in_red    = !in_blue && !in_green;
        green_off = pos_eff - PW'(w_reg);
        red_off   = pos_eff - w2_reg;
        pos_inc   = pos_eff + PW'(1);
        wrap      = pos_inc >= w3_reg;
    end

    // ------------------------------------------------------------------
    // Handshake. s1 is the slot of a plane read in flight; the output
    // register sits behind it. A new item is taken while a result waits,
    // as long as the read slot is free or drains this cycle.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic adv;
    logic accept;
    logic data_item;
    logic start_item;
    logic blue_we;
    logic green_we;
    logic rd_en;

    assign adv        = !m_valid_reg || m_ready;
    assign s_ready    = !s1_valid_reg || adv;
    assign accept     = s_valid && s_ready;
    assign data_item  = accept && (cmd_t'(s_cmd) == CMD_DATA);
    assign start_item = accept && (cmd_t'(s_cmd) == CMD_START);
    assign blue_we    = data_item && in_blue;
    assign green_we   = data_item && in_green;
    // skipped lines still write blue and green but never read
    assign rd_en      = data_item && in_red && (lines_to_skip_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg           <= '0;
            lines_to_skip_reg <= '0;
        end else if (start_item) begin
            pos_reg           <= '0;
            lines_to_skip_reg <= skip_lines_reg;
        end else if (data_item) begin
            if (wrap) begin
                pos_reg <= '0;
                if (lines_to_skip_reg != '0) begin
                    lines_to_skip_reg <= lines_to_skip_reg - SKIP_W'(1);
                end
            end else begin
                pos_reg <= pos_inc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Plane memories. Every item does at most one access, so a read never
    // meets a write in the same cycle; a write is visible to a read issued
    // on the following cycle, so no forwarding is needed.
    // ------------------------------------------------------------------
    logic [AW-1:0]     red_addr;
    logic [BYTE_W-1:0] blue_rd;
    logic [BYTE_W-1:0] green_rd;

    assign red_addr = red_off[AW-1:0];

    pl2bgr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_WIDTH)
    ) u_blue_plane (
        .clk     (aclk),
        .wr_en   (blue_we),
        .wr_addr (pos_eff[AW-1:0]),
        .wr_data (s_raw_byte),
        .rd_en   (rd_en),
        .rd_addr (red_addr),
        .rd_data (blue_rd)
    );

    pl2bgr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_WIDTH)
    ) u_green_plane (
        .clk     (aclk),
        .wr_en   (green_we),
        .wr_addr (green_off[AW-1:0]),
        .wr_data (s_raw_byte),
        .rd_en   (rd_en),
        .rd_addr (red_addr),
        .rd_data (green_rd)
    );

    // ------------------------------------------------------------------
    // Read slot: carries the fields known at accept time alongside the
    // memory read. The memory's read register holds while rd_en is low,
    // so a stalled slot keeps its blue and green bytes.
    // ------------------------------------------------------------------
    logic [DXW-1:0]    dest_full;
    logic              last_pixel;
    logic [DEST_W-1:0] s1_dest_reg;
    logic [BYTE_W-1:0] s1_red_reg;
    logic              s1_end_reg;

    assign dest_full  = DXW'(w_reg) - DXW'(1) - DXW'(red_addr);
    assign last_pixel = WW'(red_addr) == (w_reg - WW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv || !s1_valid_reg) begin
            s1_valid_reg <= rd_en;
        end
        if (rd_en) begin
            s1_dest_reg <= dest_full[DEST_W-1:0];
            s1_red_reg  <= s_raw_byte;
            s1_end_reg  <= last_pixel;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [DEST_W-1:0] m_dest_reg;
    logic [BYTE_W-1:0] m_blue_reg;
    logic [BYTE_W-1:0] m_green_reg;
    logic [BYTE_W-1:0] m_red_reg;
    logic              m_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= s1_valid_reg;
        end
        if (adv && s1_valid_reg) begin
            m_dest_reg  <= s1_dest_reg;
            m_blue_reg  <= blue_rd;
            m_green_reg <= green_rd;
            m_red_reg   <= s1_red_reg;
            m_end_reg   <= s1_end_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_dest_index = m_dest_reg;
    assign m_blue       = m_blue_reg;
    assign m_green      = m_green_reg;
    assign m_red        = m_red_reg;
    assign m_line_end   = m_end_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // a read may only start when the slot is free or drains now
    `PLMB_ASSERT_IMP(a_rd_slot_free, rd_en, !s1_valid_reg || adv)
    // one plane access per cycle
    `PLMB_ASSERT(a_one_access, !(rd_en && (blue_we || green_we)))
    // a stalled slot keeps its item
    `PLMB_ASSERT_NXT(a_slot_holds, s1_valid_reg && !adv,
                     s1_valid_reg && $stable(s1_dest_reg) && $stable(blue_rd))
    // the last pixel of a line mirrors to position zero
    `PLMB_ASSERT_IMP(a_end_at_zero, m_valid_reg && m_end_reg, m_dest_reg == '0)
    // no pixel leaves while lines are still being skipped
    `PLMB_ASSERT_IMP(a_no_skip_read, rd_en, lines_to_skip_reg == '0)

endmodule

FILE: rtl/pl2bgr_ram.sv
module pl2bgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/planar_line_to_mirrored_bgr_test.sv
module planar_line_to_mirrored_bgr_test;
    import pl2bgr_pkg::*;

    localparam int          PLANE_DEPTH   = 8192;       // DUT MAX_WIDTH
    localparam int          SETTLE_CYCLES = 4;          // read slot and output register drain, plus margin
    localparam int unsigned RANDOM_ITEMS  = 800;
    localparam int unsigned RUN_LIMIT     = 3_000_000;  // time units

    // One packed output pixel, field by field as it leaves the m_ side
    typedef struct {
        logic [DEST_W-1:0] dest_index;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
        logic              line_end;
    } bgr_pixel_t;

    // Receiver back-pressure styles, switched each time ready_tick wraps
    typedef enum logic [1:0] {
        RDY_OPEN,
        RDY_LIGHT,
        RDY_HEAVY,
        RDY_COIN
    } ready_mode_t;

    // Tracks the line position, skip count and plane contents, and holds the
    // pixels still owed by the block in arrival order.
    class bgr_line_tracker;
        int unsigned width_reg;
        int unsigned skip_reg;
        int unsigned pos;
        int unsigned skip_left;
        bit [BYTE_W-1:0] blue_mem [PLANE_DEPTH];
        bit [BYTE_W-1:0] green_mem [PLANE_DEPTH];
        bit blue_seen [PLANE_DEPTH];
        bit green_seen [PLANE_DEPTH];
        bgr_pixel_t pixels_due [$];
        int unsigned mismatches;

        function new();
            width_reg = 1;
            skip_reg = 0;
            pos = 0;
            skip_left = 0;
            mismatches = 0;
            foreach (blue_seen[i]) begin
                blue_seen[i] = 1'b0;
                green_seen[i] = 1'b0;
            end
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_LINE_WIDTH) begin
                width_reg = value;
            end else begin
                skip_reg = value[SKIP_W-1:0];
            end
        endfunction

        // zero counts as one, oversize saturates at the plane depth
        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > PLANE_DEPTH) return PLANE_DEPTH;
            return width_reg;
        endfunction

        // true if the next data byte would be a red byte whose blue or green
        // partner was never stored since reset
        function bit red_hits_unwritten();
            int unsigned w;
            int unsigned o;
            w = eff_width();
            o = (pos >= PLANES * w) ? 0 : pos;
            if (o < 2 * w) return 1'b0;
            return !(blue_seen[o - 2 * w] && green_seen[o - 2 * w]);
        endfunction

        function void note_byte(cmd_t cmd, logic [BYTE_W-1:0] data);
            int unsigned w;
            int unsigned p;
            bgr_pixel_t px;
            w = eff_width();
            if (cmd == CMD_START) begin
                pos = 0;
                skip_left = skip_reg;
                return;
            end
            // width shrank under a partial line: restart it
            if (pos >= PLANES * w) pos = 0;
            if (pos < w) begin
                blue_mem[pos] = data;
                blue_seen[pos] = 1'b1;
            end else if (pos < 2 * w) begin
                green_mem[pos - w] = data;
                green_seen[pos - w] = 1'b1;
            end else begin
                p = pos - 2 * w;
                if (skip_left == 0) begin
                    px.dest_index = DEST_W'(w - 1 - p);
                    px.blue = blue_mem[p];
                    px.green = green_mem[p];
                    px.red = data;
                    px.line_end = (p == w - 1);
                    pixels_due.push_back(px);
                end
            end
            pos++;
            if (pos >= PLANES * w) begin
                pos = 0;
                if (skip_left > 0) skip_left--;
            end
        endfunction

        function void check_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_pixel(bgr_pixel_t got);
            bgr_pixel_t want;
            if (pixels_due.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual dest %0h",
                         $time, got.dest_index);
                $display("    bgr %0h %0h %0h end %0b",
                         got.blue, got.green, got.red, got.line_end);
                mismatches++;
                return;
            end
            want = pixels_due.pop_front();
            check_field("dest_index", want.dest_index, got.dest_index);
            check_field("blue", want.blue, got.blue);
            check_field("green", want.green, got.green);
            check_field("red", want.red, got.red);
            check_field("line_end", want.line_end, got.line_end);
        endfunction

        function bit drained();
            return pixels_due.size() == 0;
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_cmd = 1'b0;
    logic [BYTE_W-1:0]     s_raw_byte = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [DEST_W-1:0]     m_dest_index;
    logic [BYTE_W-1:0]     m_blue;
    logic [BYTE_W-1:0]     m_green;
    logic [BYTE_W-1:0]     m_red;
    logic                  m_line_end;

    bgr_line_tracker sb = new();

    int unsigned burst_left = 0;
    int unsigned items_sent = 0;
    logic [7:0]  ready_tick = '0;
    ready_mode_t ready_mode = RDY_OPEN;

    planar_line_to_mirrored_bgr #(
        .MAX_WIDTH(PLANE_DEPTH)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_raw_byte  (s_raw_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dest_index(m_dest_index),
        .m_blue      (m_blue),
        .m_green     (m_green),
        .m_red       (m_red),
        .m_line_end  (m_line_end)
    );

    always #1 aclk = ~aclk;

    // Receiver: back-pressure style changes each time ready_tick wraps. Heavy mode
    // opens only when ready_tick % 5 is zero, which also backs up the input side.
    always @(posedge aclk) begin
        ready_tick <= ready_tick + 8'd1;
        if (ready_tick == 8'd0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
        case (ready_mode)
            RDY_OPEN:  m_ready <= 1'b1;
            RDY_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
            RDY_HEAVY: m_ready <= ((ready_tick % 5) == 0);
            default:   m_ready <= $urandom_range(0, 1);
        endcase
    end

    // Outputs are sampled mid-cycle, where they are settled; a handshake
    // seen here completes at the next rising edge.
    always @(negedge aclk) begin
        bgr_pixel_t got;
        if (aresetn && m_valid && m_ready) begin
            got.dest_index = m_dest_index;
            got.blue = m_blue;
            got.green = m_green;
            got.red = m_red;
            got.line_end = m_line_end;
            sb.check_pixel(got);
        end
    end

    // Stop the sender until every owed pixel has come out. Always waits on the
    // clock before the first check, so valid is never dropped and raised in the same step.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (!sb.drained());
    endtask

    // Block idle: nothing owed and the pipeline flushed of plane writes
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; only called with the block idle
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge aclk);
    endtask

    // Send one item; returns at the edge that accepted it. A data byte that
    // would read a never-written plane entry goes out as a start instead.
    task automatic put_item(input cmd_t cmd, input logic [BYTE_W-1:0] data);
        int unsigned gap;
        if (cmd == CMD_DATA && sb.red_hits_unwritten()) cmd = CMD_START;
        if (burst_left == 0) begin
            // burst/gap schedule; long unbroken bursts now and then
            if ($urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(100, 300);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 48);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        // occasional full drain mid-stream
        if ($urandom_range(0, 499) == 0) hold_until_drained();
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_raw_byte <= data;
        do @(negedge aclk); while (!s_ready);
        sb.note_byte(cmd, data);
        items_sent++;
        @(posedge aclk);
    endtask

    // n complete lines of random content at the current width
    task automatic send_scan_lines(input int unsigned n);
        repeat (n * PLANES * sb.eff_width()) put_item(CMD_DATA, BYTE_W'($urandom));
    endtask

    // Random settings, then either a clean scan (start, skipped lines, kept
    // lines) or a burst of noise with stray starts mid-line.
    task automatic random_phase();
        int unsigned w;
        int unsigned skip;
        int unsigned r;
        settle();
        r = $urandom_range(0, 19);
        if (r < 2) w = 0;
        else if (r < 13) w = $urandom_range(1, 8);
        else if (r < 18) w = $urandom_range(9, 40);
        else w = $urandom_range(41, 120);
        r = $urandom_range(0, 9);
        if (r < 6) skip = 0;
        else if (r < 9) skip = $urandom_range(1, 3);
        else begin
            skip = $urandom_range(4, 20);
            if (w > 2) w = $urandom_range(1, 2);
        end
        if (w > 40) skip = 0;
        if ($urandom_range(0, 1) == 0) begin
            write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(w));
            write_reg(CFG_SKIP_LINES, CFG_DATA_W'(skip));
        end else begin
            write_reg(CFG_SKIP_LINES, CFG_DATA_W'(skip));
            write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(w));
        end
        if ($urandom_range(0, 9) < 7) begin
            put_item(CMD_START, BYTE_W'($urandom));
            send_scan_lines(skip + ((w > 40) ? 1 : $urandom_range(1, 3)));
        end else begin
            repeat ($urandom_range(1, PLANES * sb.eff_width() + 4))
                put_item(($urandom_range(0, 11) == 0) ? CMD_START : CMD_DATA,
                         BYTE_W'($urandom));
        end
    endtask

    initial begin
        int unsigned base;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // power-on settings: width 1, no skip, one pixel per three bytes
        put_item(CMD_DATA, 8'hFF);
        put_item(CMD_DATA, 8'h00);
        put_item(CMD_DATA, 8'h80);
        put_item(CMD_START, 8'hFF);

        // width 0 behaves as width 1
        settle();
        write_reg(CFG_LINE_WIDTH, '0);
        put_item(CMD_DATA, 8'h00);
        put_item(CMD_DATA, 8'h7F);
        put_item(CMD_DATA, 8'hFF);

        // width 2 with one skipped line after the start
        settle();
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(2));
        write_reg(CFG_SKIP_LINES, CFG_DATA_W'(1));
        put_item(CMD_START, 8'h00);
        send_scan_lines(2);
        // part of a line, then a narrower width: position is past the new
        // line length so the line restarts at offset 0
        put_item(CMD_DATA, 8'h01);
        put_item(CMD_DATA, 8'hFE);
        put_item(CMD_DATA, 8'h55);
        put_item(CMD_DATA, 8'hAA);
        settle();
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(1));
        put_item(CMD_DATA, 8'h3C);
        put_item(CMD_DATA, 8'hC3);
        put_item(CMD_DATA, 8'h99);

        // widest register value saturates to the full plane depth; a short
        // run of blue bytes, then the next width change restarts the line
        settle();
        write_reg(CFG_LINE_WIDTH, '1);
        write_reg(CFG_SKIP_LINES, '0);
        put_item(CMD_START, 8'h00);
        repeat (24) put_item(CMD_DATA, BYTE_W'($urandom));

        // maximum skip count at width 1; two kept lines follow
        settle();
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(1));
        write_reg(CFG_SKIP_LINES, CFG_DATA_W'(255));
        put_item(CMD_START, 8'h5A);
        send_scan_lines(257);

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) random_phase();

        settle();
        if (sb.mismatches == 0 && sb.drained()) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule
